FILE: rtl/cgaimr_pkg.sv
// Shared types and constants for the interleaved mono raster engine.
// No dependencies; used by cgaimr_ctrl, cgaimr_dp and the top level.
package cgaimr_pkg;

    localparam int BYTES_PER_ROW = 80;
    localparam int BANK_BYTES    = 8192;
    localparam int SCREEN_ROWS   = 200;
    localparam int SCREEN_COLS   = BYTES_PER_ROW * 8;
    localparam int MEM_BYTES     = 2 * BANK_BYTES;
    localparam int ADDR_W        = $clog2(MEM_BYTES);
    localparam int BYTE_W        = $clog2(BYTES_PER_ROW);

    localparam logic [1:0] ACT_PLOT  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_HSPAN = 2'd2;
    localparam logic [1:0] ACT_VSPAN = 2'd3;

    localparam logic MODE_COPY = 1'b0;
    localparam logic MODE_XOR  = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [9:0] col;
        logic [7:0] row;
        logic [9:0] end_pos;
        logic       color;
    } t_cmd;

    typedef struct packed {
        logic pixel;
        logic error;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic clr_en;
        logic load;
        logic step;
        logic wr;
        logic finish;
        logic fail;
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic cmd_err;
        logic last;
        logic is_read;
    } t_dp_sts;

endpackage

FILE: rtl/cgaimr_ctrl.sv
// Sequencer for the raster engine: clearing pass, command accept, and
// read/write cycles per byte. Depends on cgaimr_pkg.
module cgaimr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cgaimr_pkg::t_dp_sts i_sts,
    output cgaimr_pkg::t_dp_ctl o_ctl,
    output logic                o_busy
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_WRITE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_ctl.clr_en = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) begin
                    if (i_sts.cmd_err) begin
                        o_ctl.fail = 1'b1;
                    end else begin
                        o_ctl.load = 1'b1;
                        n_state    = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_ctl.wr = !i_sts.is_read;
                if (i_sts.last) begin
                    o_ctl.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_ctl.step = 1'b1;
                    n_state    = ST_READ;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

FILE: rtl/cgaimr_dp.sv
// Datapath of the raster engine: command checks, address and mask logic,
// frame memory with clearing counter, mode register and result register.
// Depends on cgaimr_pkg.
module cgaimr_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cgaimr_pkg::t_cmd    i_cmd,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  cgaimr_pkg::t_dp_ctl i_ctl,
    output cgaimr_pkg::t_dp_sts o_sts,
    output cgaimr_pkg::t_rsp    o_rsp,
    output logic                o_valid
);

    localparam int AW = cgaimr_pkg::ADDR_W;

    logic [7:0]    mem [cgaimr_pkg::MEM_BYTES];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_clr_addr;
    logic          r_mode;
    cgaimr_pkg::t_cmd r_cmd;
    logic [6:0]    r_byte;
    logic [7:0]    r_row;
    cgaimr_pkg::t_rsp r_rsp;
    logic          r_valid;

    logic [AW:0]   addr_sum;
    logic [AW-1:0] addr;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          mem_we;
    logic          first_byte;
    logic          last_byte;
    logic [2:0]    lo;
    logic [2:0]    hi;
    logic [7:0]    mask;
    logic [7:0]    new_byte;
    logic          col_bad;
    logic          row_bad;
    logic          cmd_err;
    logic          span_last;
    logic          is_read;
    logic          clr_done;

    // command check at accept
    always_comb begin
        col_bad = (i_cmd.col >= 10'(cgaimr_pkg::SCREEN_COLS));
        row_bad = (i_cmd.row >= 8'(cgaimr_pkg::SCREEN_ROWS));
        cmd_err = col_bad || row_bad;
        if (i_cmd.action == cgaimr_pkg::ACT_HSPAN) begin
            if (i_cmd.end_pos >= 10'(cgaimr_pkg::SCREEN_COLS) || i_cmd.end_pos < i_cmd.col)
                cmd_err = 1'b1;
        end else if (i_cmd.action == cgaimr_pkg::ACT_VSPAN) begin
            if (i_cmd.end_pos >= 10'(cgaimr_pkg::SCREEN_ROWS)
                    || i_cmd.end_pos < {2'b00, i_cmd.row})
                cmd_err = 1'b1;
        end
    end

    // interleaved address: bank from row lsb, row pair times row pitch
    assign addr_sum = ((AW+1)'(r_row[0]) * (AW+1)'(cgaimr_pkg::BANK_BYTES))
                    + ((AW+1)'(r_row[7:1]) * (AW+1)'(cgaimr_pkg::BYTES_PER_ROW))
                    + (AW+1)'(r_byte);
    assign addr = addr_sum[AW-1:0];

    assign first_byte = (r_byte == r_cmd.col[9:3]);
    assign last_byte  = (r_byte == r_cmd.end_pos[9:3]);

    always_comb begin
        lo = first_byte ? r_cmd.col[2:0] : 3'd0;
        hi = last_byte ? r_cmd.end_pos[2:0] : 3'd7;
        if (r_cmd.action == cgaimr_pkg::ACT_HSPAN)
            mask = (8'hFF >> lo) & (8'hFF << (3'd7 - hi));
        else
            mask = 8'h80 >> r_cmd.col[2:0];
    end

    always_comb begin
        case (r_cmd.action)
            cgaimr_pkg::ACT_HSPAN: span_last = last_byte;
            cgaimr_pkg::ACT_VSPAN: span_last = (r_row == r_cmd.end_pos[7:0]);
            default:               span_last = 1'b1;
        endcase
    end

    assign is_read  = (r_cmd.action == cgaimr_pkg::ACT_READ);
    assign clr_done = (r_clr_addr == {AW{1'b1}});

    // member order: clr_last, cmd_err, last, is_read
    assign o_sts = {clr_done, cmd_err, span_last, is_read};

    always_comb begin
        if (r_mode == cgaimr_pkg::MODE_XOR)
            new_byte = r_cmd.color ? (r_rdata ^ mask) : r_rdata;
        else
            new_byte = r_cmd.color ? (r_rdata | mask) : (r_rdata & ~mask);
    end

    assign mem_we = i_ctl.clr_en || i_ctl.wr;
    assign waddr  = i_ctl.clr_en ? r_clr_addr : addr;
    assign wdata  = i_ctl.clr_en ? 8'h00 : new_byte;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[waddr] <= wdata;
        r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_mode     <= cgaimr_pkg::MODE_COPY;
            r_valid    <= 1'b0;
        end else begin
            if (i_ctl.clr_en) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cfg_we) r_mode <= i_cfg_data;
            r_valid <= i_ctl.finish || i_ctl.fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_byte <= i_cmd.col[9:3];
            r_row  <= i_cmd.row;
        end else if (i_ctl.step) begin
            if (r_cmd.action == cgaimr_pkg::ACT_HSPAN)
                r_byte <= r_byte + 1'b1;
            else
                r_row <= r_row + 1'b1;
        end
        if (i_ctl.fail) begin
            r_rsp.pixel <= 1'b0;
            r_rsp.error <= 1'b1;
        end else if (i_ctl.finish) begin
            r_rsp.pixel <= is_read && ((r_rdata & mask) != 8'h00);
            r_rsp.error <= 1'b0;
        end
    end

    assign o_rsp   = r_rsp;
    assign o_valid = r_valid;

endmodule

FILE: rtl/cga_interleaved_mono_raster_engine_core.sv
// Top level of the interleaved mono raster engine: controller plus datapath.
// Depends on cgaimr_pkg, cgaimr_ctrl, cgaimr_dp.
//
//   port group        direction  handshake
//   i_cmd  / start    in         taken when start is high and busy is low
//   o_rsp  / o_valid  out        one-cycle strobe, no backpressure
//   i_cfg_data/_we    in         draw mode written when i_cfg_we is high
//
// Each byte touched goes through a read state, then a modify-write state:
// plot and read touch one byte, a horizontal span each byte it covers, a
// vertical span one byte per row. The result strobe rises in the cycle
// after the last write state; for a rejected command, in the cycle after
// it is taken. After reset all 16384 bytes of frame memory are swept to
// zero, one byte a cycle, busy high; the receiver never holds results off.
module cga_interleaved_mono_raster_engine_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  cgaimr_pkg::t_cmd i_cmd,
    input  logic             i_cfg_we,
    input  logic             i_cfg_data,
    output cgaimr_pkg::t_rsp o_rsp,
    output logic             o_valid
);

    cgaimr_pkg::t_dp_ctl ctl;
    cgaimr_pkg::t_dp_sts sts;

    cgaimr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    cgaimr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_rsp      (o_rsp),
        .o_valid    (o_valid)
    );

endmodule

FILE: test/tb_top.sv
// Testbench for cga_interleaved_mono_raster_engine_core: directed and random
// drawing commands checked against a shadow frame buffer held in the bench.
// Depends on cgaimr_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int HALF_PERIOD    = 6;
    localparam int WATCHDOG_LIMIT = 60000;  // outlasts the clear sweep after reset
    localparam int TAIL_ITEMS     = 150;    // no sender gaps over the last items
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {
        ITEM_CMD,
        ITEM_MODE,
        ITEM_FLUSH
    } t_item_kind;

    typedef struct {
        t_item_kind       kind;
        cgaimr_pkg::t_cmd cmd;
        logic             mode;
    } t_backlog_item;

    logic i_clk    = 1'b0;
    logic i_rst_n  = 1'b0;
    logic start    = 1'b0;
    cgaimr_pkg::t_cmd cmd_drv = '0;
    logic cfg_we   = 1'b0;
    logic cfg_data = 1'b0;
    logic busy;
    cgaimr_pkg::t_rsp rsp;
    logic rsp_valid;

    t_backlog_item    cmd_backlog[$];
    cgaimr_pkg::t_rsp pending_rsp[$];

    logic [7:0] shadow_fb [0:cgaimr_pkg::MEM_BYTES-1];
    logic       raster_mode;

    logic cmd_taken = 1'b0;
    logic busy_q    = 1'b1;
    int   mismatch_cnt = 0;
    int   stall_cycles = 0;
    int   gap_cnt      = 0;
    int   quiet_cnt    = 0;
    bit   gap_used     = 1'b0;

    cga_interleaved_mono_raster_engine_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (cmd_drv),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_rsp      (rsp),
        .o_valid    (rsp_valid)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ---------------------------------------------------------------- shadow model

    function automatic int unsigned fb_addr(input int unsigned colbyte, input int unsigned r);
        return ((r & 1) * cgaimr_pkg::BANK_BYTES + (r >> 1) * cgaimr_pkg::BYTES_PER_ROW
                + colbyte) % cgaimr_pkg::MEM_BYTES;
    endfunction

    function automatic logic [7:0] bit_mask(input int unsigned c);
        return 8'h80 >> (c & 7);
    endfunction

    function automatic void paint(input int unsigned a, input logic [7:0] m,
                                  input logic color);
        if (raster_mode == cgaimr_pkg::MODE_XOR) begin
            if (color)
                shadow_fb[a] = shadow_fb[a] ^ m;
        end else if (color) begin
            shadow_fb[a] = shadow_fb[a] | m;
        end else begin
            shadow_fb[a] = shadow_fb[a] & ~m;
        end
    endfunction

    // Applies one command to the shadow buffer and returns the response it earns.
    function automatic cgaimr_pkg::t_rsp draw_and_respond(input cgaimr_pkg::t_cmd c);
        cgaimr_pkg::t_rsp r;
        int unsigned first_b;
        int unsigned last_b;
        int unsigned lo;
        int unsigned hi;
        logic [7:0]  m;
        r = '0;
        if (c.col >= cgaimr_pkg::SCREEN_COLS || c.row >= cgaimr_pkg::SCREEN_ROWS) begin
            r.error = 1'b1;
        end else begin
            case (c.action)
                cgaimr_pkg::ACT_PLOT: begin
                    paint(fb_addr(32'(c.col >> 3), 32'(c.row)), bit_mask(32'(c.col)),
                          c.color);
                end
                cgaimr_pkg::ACT_READ: begin
                    r.pixel = |(shadow_fb[fb_addr(32'(c.col >> 3), 32'(c.row))]
                                & bit_mask(32'(c.col)));
                end
                cgaimr_pkg::ACT_HSPAN: begin
                    if (c.end_pos >= cgaimr_pkg::SCREEN_COLS || c.end_pos < c.col) begin
                        r.error = 1'b1;
                    end else begin
                        first_b = 32'(c.col >> 3);
                        last_b  = 32'(c.end_pos >> 3);
                        for (int unsigned b = first_b; b <= last_b; b++) begin
                            lo = (b == first_b) ? (c.col & 7) : 0;
                            hi = (b == last_b) ? (c.end_pos & 7) : 7;
                            m  = (8'hFF >> lo) & (8'hFF << (7 - hi));
                            paint(fb_addr(b, 32'(c.row)), m, c.color);
                        end
                    end
                end
                default: begin
                    if (c.end_pos >= cgaimr_pkg::SCREEN_ROWS || c.end_pos < c.row) begin
                        r.error = 1'b1;
                    end else begin
                        for (int unsigned y = 32'(c.row); y <= c.end_pos; y++)
                            paint(fb_addr(32'(c.col >> 3), y), bit_mask(32'(c.col)),
                                  c.color);
                    end
                end
            endcase
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void add_cmd(input logic [1:0] action, input int unsigned col,
                                    input int unsigned row, input int unsigned end_pos,
                                    input logic color);
        t_backlog_item it;
        it.kind        = ITEM_CMD;
        it.cmd.action  = action;
        it.cmd.col     = col[9:0];
        it.cmd.row     = row[7:0];
        it.cmd.end_pos = end_pos[9:0];
        it.cmd.color   = color;
        it.mode        = 1'b0;
        cmd_backlog.push_back(it);
    endfunction

    function automatic void add_marker(input t_item_kind kind, input logic mode);
        t_backlog_item it;
        it.kind = kind;
        it.cmd  = '0;
        it.mode = mode;
        cmd_backlog.push_back(it);
    endfunction

    // Mostly in-range commands clustered in a small corner so reads hit drawn
    // pixels; spans are short with the odd full-length one; the rest is noise.
    function automatic void add_random(input int n);
        int unsigned sel;
        int unsigned col;
        int unsigned row;
        int unsigned end_pos;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 6) begin
                col = $urandom_range(0, 79);
                row = $urandom_range(0, 11);
            end else begin
                col = $urandom_range(0, cgaimr_pkg::SCREEN_COLS - 1);
                row = $urandom_range(0, cgaimr_pkg::SCREEN_ROWS - 1);
            end
            end_pos = $urandom_range(0, 1023);
            if (sel < 30) begin
                add_cmd(cgaimr_pkg::ACT_PLOT, col, row, end_pos, 1'($urandom_range(0, 1)));
            end else if (sel < 60) begin
                add_cmd(cgaimr_pkg::ACT_READ, col, row, end_pos, 1'($urandom_range(0, 1)));
            end else if (sel < 75) begin
                if ($urandom_range(0, 19) == 0) begin
                    col     = $urandom_range(0, 15);
                    end_pos = $urandom_range(cgaimr_pkg::SCREEN_COLS - 40,
                                             cgaimr_pkg::SCREEN_COLS - 1);
                end else begin
                    end_pos = col + $urandom_range(0, 40);
                    if (end_pos > cgaimr_pkg::SCREEN_COLS - 1)
                        end_pos = cgaimr_pkg::SCREEN_COLS - 1;
                end
                add_cmd(cgaimr_pkg::ACT_HSPAN, col, row, end_pos, 1'($urandom_range(0, 1)));
            end else if (sel < 87) begin
                if ($urandom_range(0, 19) == 0) begin
                    row     = $urandom_range(0, 5);
                    end_pos = $urandom_range(cgaimr_pkg::SCREEN_ROWS - 10,
                                             cgaimr_pkg::SCREEN_ROWS - 1);
                end else begin
                    end_pos = row + $urandom_range(0, 10);
                    if (end_pos > cgaimr_pkg::SCREEN_ROWS - 1)
                        end_pos = cgaimr_pkg::SCREEN_ROWS - 1;
                end
                add_cmd(cgaimr_pkg::ACT_VSPAN, col, row, end_pos, 1'($urandom_range(0, 1)));
            end else if (sel < 93) begin
                // span with the end before the start
                if ($urandom_range(0, 1) == 0)
                    add_cmd(cgaimr_pkg::ACT_HSPAN, col + 1, row, $urandom_range(0, col), 1'b1);
                else
                    add_cmd(cgaimr_pkg::ACT_VSPAN, col, row + 1, $urandom_range(0, row), 1'b1);
            end else begin
                add_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                        $urandom_range(0, 255), $urandom_range(0, 1023),
                        1'($urandom_range(0, 1)));
            end
        end
    endfunction

    // ---------------------------------------------------------------- driver

    always @(negedge i_clk) begin : driver
        logic nxt_start;
        cgaimr_pkg::t_cmd nxt_cmd;
        logic nxt_we;
        logic nxt_data;
        nxt_start = start;
        nxt_cmd   = cmd_drv;
        nxt_we    = 1'b0;
        nxt_data  = cfg_data;
        if (i_rst_n && !(start && !cmd_taken)) begin
            nxt_start = 1'b0;
            if (gap_cnt > 0) begin
                gap_cnt--;
            end else if (cmd_backlog.size() > 0) begin
                if (cmd_backlog[0].kind == ITEM_CMD) begin
                    if (!gap_used && cmd_backlog.size() > TAIL_ITEMS &&
                        $urandom_range(0, 3) == 0) begin
                        gap_cnt  = $urandom_range(0, 4);
                        gap_used = 1'b1;
                    end else begin
                        nxt_start = 1'b1;
                        nxt_cmd   = cmd_backlog[0].cmd;
                        void'(cmd_backlog.pop_front());
                        gap_used  = 1'b0;
                    end
                end else if (pending_rsp.size() == 0 && !busy_q) begin
                    // engine drained: let it settle before a mode write or a flush
                    if (quiet_cnt >= SETTLE_CYCLES) begin
                        if (cmd_backlog[0].kind == ITEM_MODE) begin
                            nxt_we   = 1'b1;
                            nxt_data = cmd_backlog[0].mode;
                        end
                        void'(cmd_backlog.pop_front());
                        quiet_cnt = 0;
                    end else begin
                        quiet_cnt++;
                    end
                end else begin
                    quiet_cnt = 0;
                end
            end
        end
        start    <= nxt_start;
        cmd_drv  <= nxt_cmd;
        cfg_we   <= nxt_we;
        cfg_data <= nxt_data;
    end

    // ---------------------------------------------------------------- monitor

    function automatic void note_mismatch(input string what, input logic exp_v,
                                          input logic act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0b, got %0b", $time, what, exp_v, act_v);
    endfunction

    always @(posedge i_clk) begin : monitor
        cgaimr_pkg::t_rsp exp_rsp;
        cmd_taken <= start && !busy;
        busy_q    <= busy;
        if (i_rst_n) begin
            if (rsp_valid) begin
                if (pending_rsp.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: response with no transaction outstanding: %s %0b %0b",
                                 $time, "pixel/error", rsp.pixel, rsp.error);
                end else begin
                    exp_rsp = pending_rsp.pop_front();
                    if (rsp.pixel !== exp_rsp.pixel)
                        note_mismatch("pixel", exp_rsp.pixel, rsp.pixel);
                    if (rsp.error !== exp_rsp.error)
                        note_mismatch("error", exp_rsp.error, rsp.error);
                end
            end
            if (cfg_we)
                raster_mode = cfg_data;
            if (start && !busy)
                pending_rsp.push_back(draw_and_respond(cmd_drv));
            if ((start && !busy) || rsp_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        foreach (shadow_fb[a])
            shadow_fb[a] = 8'h00;
        raster_mode = cgaimr_pkg::MODE_COPY;

        // copy mode: corners, out-of-range fields, span edges
        add_marker(ITEM_MODE, cgaimr_pkg::MODE_COPY);
        add_cmd(cgaimr_pkg::ACT_PLOT,  0, 0, 0, 1'b1);
        add_cmd(cgaimr_pkg::ACT_READ,  0, 0, 1023, 1'b1);
        add_cmd(cgaimr_pkg::ACT_READ,  1, 0, 0, 1'b0);
        add_cmd(cgaimr_pkg::ACT_PLOT,  cgaimr_pkg::SCREEN_COLS - 1,
                cgaimr_pkg::SCREEN_ROWS - 1, 1023, 1'b1);
        add_cmd(cgaimr_pkg::ACT_READ,  cgaimr_pkg::SCREEN_COLS - 1,
                cgaimr_pkg::SCREEN_ROWS - 1, 0, 1'b0);
        add_cmd(cgaimr_pkg::ACT_PLOT,  cgaimr_pkg::SCREEN_COLS, 0, 0, 1'b1);
        add_cmd(cgaimr_pkg::ACT_READ,  0, cgaimr_pkg::SCREEN_ROWS, 0, 1'b0);
        add_cmd(cgaimr_pkg::ACT_PLOT,  1023, 255, 1023, 1'b1);
        add_cmd(cgaimr_pkg::ACT_HSPAN, 0, 1, cgaimr_pkg::SCREEN_COLS - 1, 1'b1);
        add_cmd(cgaimr_pkg::ACT_READ,  320, 1, 0, 1'b0);
        add_cmd(cgaimr_pkg::ACT_HSPAN, 3, 2, 5, 1'b1);
        add_cmd(cgaimr_pkg::ACT_HSPAN, 7, 2, 8, 1'b1);
        add_cmd(cgaimr_pkg::ACT_HSPAN, 10, 3, 9, 1'b1);
        add_cmd(cgaimr_pkg::ACT_HSPAN, 0, 3, cgaimr_pkg::SCREEN_COLS, 1'b1);
        add_cmd(cgaimr_pkg::ACT_VSPAN, 5, 0, cgaimr_pkg::SCREEN_ROWS - 1, 1'b1);
        add_cmd(cgaimr_pkg::ACT_READ,  5, 100, 0, 1'b1);
        add_cmd(cgaimr_pkg::ACT_VSPAN, 6, 10, 9, 1'b1);
        add_cmd(cgaimr_pkg::ACT_VSPAN, 6, 0, cgaimr_pkg::SCREEN_ROWS, 1'b1);
        add_cmd(cgaimr_pkg::ACT_VSPAN, 7, 7, 7, 1'b1);
        add_cmd(cgaimr_pkg::ACT_PLOT,  0, 0, 555, 1'b0);
        add_cmd(cgaimr_pkg::ACT_READ,  0, 0, 0, 1'b0);
        add_cmd(cgaimr_pkg::ACT_HSPAN, 100, 1, 539, 1'b0);
        // xor mode: colour 0 is a no-op, colour 1 inverts
        add_marker(ITEM_MODE, cgaimr_pkg::MODE_XOR);
        add_cmd(cgaimr_pkg::ACT_PLOT,  0, 0, 0, 1'b1);
        add_cmd(cgaimr_pkg::ACT_PLOT,  0, 0, 0, 1'b0);
        add_cmd(cgaimr_pkg::ACT_READ,  0, 0, 0, 1'b0);
        add_cmd(cgaimr_pkg::ACT_HSPAN, 90, 1, 549, 1'b1);
        add_cmd(cgaimr_pkg::ACT_VSPAN, 5, 50, 60, 1'b1);
        add_cmd(cgaimr_pkg::ACT_READ,  5, 55, 0, 1'b0);
        add_marker(ITEM_FLUSH, 1'b0);

        add_random(230);
        add_marker(ITEM_MODE, cgaimr_pkg::MODE_COPY);
        add_random(115);
        add_marker(ITEM_FLUSH, 1'b0);
        add_random(115);
        add_marker(ITEM_MODE, cgaimr_pkg::MODE_XOR);
        add_random(230);
        add_marker(ITEM_MODE, cgaimr_pkg::MODE_COPY);
        add_random(230);
        add_marker(ITEM_MODE, cgaimr_pkg::MODE_XOR);
        add_random(230);

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start)
            @(negedge i_clk);
        while (pending_rsp.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/cgaimr_pkg.sv
rtl/cgaimr_ctrl.sv
rtl/cgaimr_dp.sv
rtl/cga_interleaved_mono_raster_engine_core.sv
test/tb_top.sv
